### design/ir_pulse_learn_capture_macros.svh
// ----------------------------------------------------------------------------
// IR pulse learn capture assertion macros
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_LEARN_CAPTURE_MACROS_SVH
`define IR_PULSE_LEARN_CAPTURE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define IPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define IPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IPL_ASSERT_IMP(lbl, ante, cons, msg)
`define IPL_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### design/ipl_pkg.sv
// ----------------------------------------------------------------------------
// IR pulse learn capture package
// Field widths, command and status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package ipl_pkg;

  localparam int unsigned CMD_W         = 2;
  localparam int unsigned CAP_W         = 16;
  localparam int unsigned IDX_W         = 9;
  localparam int unsigned STATUS_W      = 4;
  localparam int unsigned CNT_W         = 10;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 10;
  localparam int unsigned STORE_DEPTH_DEF = 512;

  localparam logic [CNT_W-1:0] COUNT_MAX   = 10'd1023;
  localparam logic [CNT_W-1:0] MIN_EDGES_RST = 10'd72;
  localparam logic [CNT_W-1:0] MAX_EDGES_RST = 10'd280;

  typedef enum logic [CMD_W-1:0] {
    CMD_EDGE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_LEARN = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IDLE      = 4'd0,
    ST_STORED    = 4'd1,
    ST_MEASURED  = 4'd2,
    ST_SNAPSHOT  = 4'd3,
    ST_COMMITTED = 4'd4,
    ST_REJECTED  = 4'd5,
    ST_ENDED     = 4'd6,
    ST_RESTARTED = 4'd7,
    ST_READ      = 4'd8,
    ST_LEARNING  = 4'd9
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_EDGES = 2'd0,
    CFG_MAX_EDGES = 2'd1
  } cfg_sel_t;

endpackage

`default_nettype wire

### design/ipl_ifs.sv
// ----------------------------------------------------------------------------
// IR pulse learn capture channels
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipl_item_if;
  import ipl_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [CAP_W-1:0] capture_value;
  logic [IDX_W-1:0] read_index;
  modport source (output valid, cmd, capture_value, read_index, input ready);
  modport sink   (input valid, cmd, capture_value, read_index, output ready);
endinterface

interface ipl_result_if;
  import ipl_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    edge_count;
  logic                next_edge_rising;
  logic                learning_active;
  logic [CNT_W-1:0]    saved_length;
  logic [CAP_W-1:0]    last_capture;
  logic [CAP_W-1:0]    read_data;
  modport source (output valid, status, edge_count, next_edge_rising, learning_active,
                  saved_length, last_capture, read_data, input ready);
  modport sink   (input valid, status, edge_count, next_edge_rising, learning_active,
                  saved_length, last_capture, read_data, output ready);
endinterface

interface ipl_cfg_if;
  import ipl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/ipl_ram.sv
// ----------------------------------------------------------------------------
// IR pulse learn capture RAM
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ipl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/ir_pulse_learn_capture.sv
// ----------------------------------------------------------------------------
// IR pulse learn capture
// Edge counting, pulse store for learned frames, frame-end detection.
//
//   channel  dir  word
//   cfg      in   index, data (min / max learned frame length)
//   item     in   cmd, capture_value, read_index
//   result   out  status, counters, last capture, read data
//
// One word per cycle while the result sink keeps up; a result appears in the
// cycle after its word is taken, once the registered pulse store read returns.
// The result register holds while the sink stalls; a new word is taken
// whenever the result register is empty or being drained.
// rst clears the counters and state flags and reloads the default bounds; the
// pulse store and the status and read-hit registers are not cleared.
// cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_learn_capture #(
  parameter int unsigned STORE_DEPTH = ipl_pkg::STORE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ipl_cfg_if.sink     cfg,
  ipl_item_if.sink    item,
  ipl_result_if.source result
);

  import ipl_pkg::*;

  localparam int unsigned AW = $clog2(STORE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

  logic [CNT_W-1:0] min_edges;
  logic [CNT_W-1:0] max_edges;

  logic [CNT_W-1:0] edge_counter, edge_counter_next;
  logic [CNT_W-1:0] count_snapshot, count_snapshot_next;
  logic             idle_tick_seen, idle_tick_seen_next;
  logic             expect_rising, expect_rising_next;
  logic             learn_mode, learn_mode_next;
  logic [CNT_W-1:0] learned_length, learned_length_next;
  logic [CAP_W-1:0] measured_duration, measured_duration_next;

  logic             out_valid;
  status_t          status, status_next;
  logic             rd_hit, rd_hit_next;

  logic             acc;
  logic             ram_we;
  logic             ram_re;
  logic [CNT_W-1:0] idx_ext;
  logic [CAP_W-1:0] ram_rdata;

  assign cfg.ready  = 1'b1;
  assign item.ready = !out_valid || result.ready;
  assign acc        = item.valid && item.ready;
  assign idx_ext    = CNT_W'(item.read_index);

  always_comb begin
    edge_counter_next      = edge_counter;
    count_snapshot_next    = count_snapshot;
    idle_tick_seen_next    = idle_tick_seen;
    expect_rising_next     = expect_rising;
    learn_mode_next        = learn_mode;
    learned_length_next    = learned_length;
    measured_duration_next = measured_duration;
    status_next            = ST_IDLE;
    rd_hit_next            = 1'b0;
    ram_we                 = 1'b0;
    ram_re                 = 1'b0;
    if (acc) begin
      unique case (cmd_t'(item.cmd))
        CMD_EDGE: begin
          idle_tick_seen_next = 1'b0;
          if (learn_mode) begin
            ram_we      = edge_counter < DEPTH_CNT;
            status_next = ST_STORED;
          end else begin
            measured_duration_next = item.capture_value;
            status_next            = ST_MEASURED;
          end
          if (edge_counter != COUNT_MAX) begin
            edge_counter_next = edge_counter + 1'b1;
          end
          expect_rising_next = !expect_rising;
        end
        CMD_TICK: begin
          priority if (edge_counter == '0) begin
            status_next = ST_IDLE;
          end else if (!idle_tick_seen) begin
            count_snapshot_next = edge_counter;
            idle_tick_seen_next = 1'b1;
            status_next         = ST_SNAPSHOT;
          end else begin
            if (edge_counter == count_snapshot) begin
              if (learn_mode) begin
                learned_length_next = count_snapshot;
                if (count_snapshot >= min_edges && count_snapshot <= max_edges) begin
                  learn_mode_next = 1'b0;
                  status_next     = ST_COMMITTED;
                end else begin
                  status_next = ST_REJECTED;
                end
              end else begin
                status_next = ST_ENDED;
              end
            end else begin
              status_next = ST_RESTARTED;
            end
            edge_counter_next   = '0;
            count_snapshot_next = '0;
            idle_tick_seen_next = 1'b0;
            expect_rising_next  = 1'b0;
          end
        end
        CMD_LEARN: begin
          learn_mode_next = 1'b1;
          status_next     = ST_LEARNING;
        end
        CMD_READ: begin
          status_next = ST_READ;
          rd_hit_next = (idx_ext < learned_length) && (idx_ext < DEPTH_CNT);
          ram_re      = rd_hit_next;
        end
        default: begin
          status_next = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_edges         <= MIN_EDGES_RST;
      max_edges         <= MAX_EDGES_RST;
      edge_counter      <= '0;
      count_snapshot    <= '0;
      idle_tick_seen    <= 1'b0;
      expect_rising     <= 1'b0;
      learn_mode        <= 1'b0;
      learned_length    <= '0;
      measured_duration <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg_sel_t'(cfg.index))
          CFG_MIN_EDGES: min_edges <= cfg.data;
          CFG_MAX_EDGES: max_edges <= cfg.data;
          default: begin
          end
        endcase
      end
      edge_counter      <= edge_counter_next;
      count_snapshot    <= count_snapshot_next;
      idle_tick_seen    <= idle_tick_seen_next;
      expect_rising     <= expect_rising_next;
      learn_mode        <= learn_mode_next;
      learned_length    <= learned_length_next;
      measured_duration <= measured_duration_next;
      if (acc) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status <= status_next;
      rd_hit <= rd_hit_next;
    end
  end

  ipl_ram #(
    .WIDTH (CAP_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (edge_counter[AW-1:0]),
    .wdata (item.capture_value),
    .re    (ram_re),
    .raddr (idx_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign result.valid            = out_valid;
  assign result.status           = status;
  assign result.edge_count       = edge_counter;
  assign result.next_edge_rising = expect_rising;
  assign result.learning_active  = learn_mode;
  assign result.saved_length     = learned_length;
  assign result.last_capture     = measured_duration;
  assign result.read_data        = rd_hit ? ram_rdata : '0;

`include "ir_pulse_learn_capture_macros.svh"

  `IPL_ASSERT_NXT(a_count_step, acc && item.cmd == CMD_EDGE && edge_counter != COUNT_MAX, edge_counter == $past(edge_counter) + 1'b1, "edge count did not advance")
  `IPL_ASSERT_IMP(a_rd_zero, out_valid && status != ST_READ, result.read_data == '0, "read data outside a read")
  `IPL_ASSERT_IMP(a_tick_state, idle_tick_seen, edge_counter == count_snapshot && edge_counter != '0, "snapshot out of step with count")
  `IPL_ASSERT_IMP(a_learn_exit, $fell(learn_mode) && !$past(rst), $past(acc && item.cmd == CMD_TICK), "learning left without a tick")

endmodule

`default_nettype wire

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// IR pulse learn capture testbench
// Drives edge, tick, learn and read words into the item channel and checks every
// result word against a cycle-free predictor of the capture logic or a directed
// row's word. A directed script precedes random learned and measured frames
// under several frame-length bounds, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ipl_pkg::*;

  localparam int MEM_DEPTH   = STORE_DEPTH_DEF;
  localparam int ITEM_TARGET = 1930;
  localparam int QUIET_START = ITEM_TARGET - 250;
  localparam int LONG_HOLD   = 48;

  typedef struct packed {
    status_t           status;
    logic [CNT_W-1:0]  edge_count;
    logic              next_rising;
    logic              learning;
    logic [CNT_W-1:0]  saved_length;
    logic [CAP_W-1:0]  last_capture;
    logic [CAP_W-1:0]  read_data;
  } cap_result_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    cmd_t              cmd;
    logic [CAP_W-1:0]  cap;
    logic [IDX_W-1:0]  idx;
    cfg_sel_t          sel;
    logic [CNT_W-1:0]  value;
    logic              typed;
    cap_result_t       want;
  } script_row_t;

  localparam cap_result_t NO_RESULT = '0;

  localparam script_row_t DIRECTED [30] = '{
    '{ROW_WORD, CMD_TICK, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b1,
      '{ST_IDLE, 10'd0, 1'b0, 1'b0, 10'd0, 16'h0000, 16'h0000}},
    '{ROW_WORD, CMD_READ, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b1,
      '{ST_READ, 10'd0, 1'b0, 1'b0, 10'd0, 16'h0000, 16'h0000}},
    '{ROW_WORD, CMD_READ, 16'hFFFF, 9'd511, CFG_MIN_EDGES, 10'd0, 1'b1,
      '{ST_READ, 10'd0, 1'b0, 1'b0, 10'd0, 16'h0000, 16'h0000}},
    '{ROW_WORD, CMD_EDGE, 16'hFFFF, 9'd511, CFG_MIN_EDGES, 10'd0, 1'b1,
      '{ST_MEASURED, 10'd1, 1'b1, 1'b0, 10'd0, 16'hFFFF, 16'h0000}},
    '{ROW_WORD, CMD_EDGE, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b1,
      '{ST_MEASURED, 10'd2, 1'b0, 1'b0, 10'd0, 16'h0000, 16'h0000}},
    '{ROW_WORD, CMD_TICK, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b1,
      '{ST_SNAPSHOT, 10'd2, 1'b0, 1'b0, 10'd0, 16'h0000, 16'h0000}},
    '{ROW_WORD, CMD_EDGE, 16'd1234, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_TICK, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_TICK, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b1,
      '{ST_ENDED, 10'd0, 1'b0, 1'b0, 10'd0, 16'd1234, 16'h0000}},
    '{ROW_WORD, CMD_LEARN, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b1,
      '{ST_LEARNING, 10'd0, 1'b0, 1'b1, 10'd0, 16'd1234, 16'h0000}},
    '{ROW_WORD, CMD_EDGE, 16'hA5A5, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_EDGE, 16'h5A5A, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_TICK, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_TICK, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b1,
      '{ST_REJECTED, 10'd0, 1'b0, 1'b1, 10'd2, 16'd1234, 16'h0000}},
    '{ROW_WORD, CMD_READ, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b1,
      '{ST_READ, 10'd0, 1'b0, 1'b1, 10'd2, 16'd1234, 16'hA5A5}},
    '{ROW_WORD, CMD_READ, 16'h0000, 9'd1, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_READ, 16'h0000, 9'd2, CFG_MIN_EDGES, 10'd0, 1'b1,
      '{ST_READ, 10'd0, 1'b0, 1'b1, 10'd2, 16'd1234, 16'h0000}},
    '{ROW_REG, CMD_EDGE, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd2, 1'b0, NO_RESULT},
    '{ROW_REG, CMD_EDGE, 16'h0000, 9'd0, CFG_MAX_EDGES, 10'd2, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_EDGE, 16'h0001, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_EDGE, 16'h8000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_TICK, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_TICK, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b1,
      '{ST_COMMITTED, 10'd0, 1'b0, 1'b0, 10'd2, 16'd1234, 16'h0000}},
    '{ROW_WORD, CMD_READ, 16'h0000, 9'd1, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT},
    '{ROW_REG, CMD_EDGE, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd512, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_LEARN, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_EDGE, 16'h7FFF, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_TICK, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT},
    '{ROW_WORD, CMD_TICK, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b1,
      '{ST_REJECTED, 10'd0, 1'b0, 1'b1, 10'd1, 16'd1234, 16'h0000}},
    '{ROW_WORD, CMD_READ, 16'h0000, 9'd0, CFG_MIN_EDGES, 10'd0, 1'b0, NO_RESULT}
  };

  logic clk;
  logic rst;

  ipl_cfg_if    cfg_ch ();
  ipl_item_if   item_ch ();
  ipl_result_if res_ch ();

  ir_pulse_learn_capture uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (res_ch)
  );

  logic [CNT_W-1:0] edges_seen;
  logic [CNT_W-1:0] edges_at_tick;
  logic             tick_armed;
  logic             rising_next;
  logic             learning;
  logic [CNT_W-1:0] frame_len;
  logic [CAP_W-1:0] last_dur;
  logic [CNT_W-1:0] min_len;
  logic [CNT_W-1:0] max_len;
  logic [CAP_W-1:0] pulse_mem [MEM_DEPTH];
  bit               stored_ok [MEM_DEPTH];

  cap_result_t capture_results_due [$];
  int          items_sent;
  int          fails;
  bit          gaps_on;
  bit          hold_long;

  function automatic cap_result_t predict_capture(input cmd_t c, input logic [CAP_W-1:0] cap,
                                                  input logic [IDX_W-1:0] idx);
    cap_result_t r;
    r.status    = ST_IDLE;
    r.read_data = '0;
    case (c)
      CMD_EDGE: begin
        tick_armed = 1'b0;
        if (learning) begin
          if (edges_seen < MEM_DEPTH) begin
            pulse_mem[edges_seen[IDX_W-1:0]] = cap;
            stored_ok[edges_seen[IDX_W-1:0]] = 1'b1;
          end
          r.status = ST_STORED;
        end else begin
          last_dur = cap;
          r.status = ST_MEASURED;
        end
        if (edges_seen != COUNT_MAX) edges_seen = edges_seen + 1'b1;
        rising_next = ~rising_next;
      end
      CMD_TICK: begin
        if (edges_seen == 0) begin
          r.status = ST_IDLE;
        end else if (!tick_armed) begin
          edges_at_tick = edges_seen;
          tick_armed    = 1'b1;
          r.status      = ST_SNAPSHOT;
        end else begin
          if (edges_seen == edges_at_tick) begin
            if (learning) begin
              frame_len = edges_at_tick;
              if (frame_len >= min_len && frame_len <= max_len) begin
                learning = 1'b0;
                r.status = ST_COMMITTED;
              end else begin
                r.status = ST_REJECTED;
              end
            end else begin
              r.status = ST_ENDED;
            end
          end else begin
            r.status = ST_RESTARTED;
          end
          edges_seen    = '0;
          edges_at_tick = '0;
          tick_armed    = 1'b0;
          rising_next   = 1'b0;
        end
      end
      CMD_LEARN: begin
        learning = 1'b1;
        r.status = ST_LEARNING;
      end
      default: begin
        r.status = ST_READ;
        if (idx < frame_len && idx < MEM_DEPTH) r.read_data = pulse_mem[idx];
      end
    endcase
    r.edge_count   = edges_seen;
    r.next_rising  = rising_next;
    r.learning     = learning;
    r.saved_length = frame_len;
    r.last_capture = last_dur;
    return r;
  endfunction

  function automatic string result_text(input cap_result_t r);
    return $sformatf("status=%0d count=%0d rising=%0b learn=%0b saved=%0d last=%h read=%h",
                     r.status, r.edge_count, r.next_rising, r.learning, r.saved_length,
                     r.last_capture, r.read_data);
  endfunction

  // never pick an index below the saved length whose entry holds no learned pulse
  function automatic bit safe_read_index(output logic [IDX_W-1:0] idx);
    int k;
    int span;
    span = (frame_len > MEM_DEPTH) ? MEM_DEPTH : int'(frame_len);
    idx  = '0;
    for (k = 0; k < 16; k++) begin
      if (span != 0 && $urandom_range(0, 2) != 0)
        idx = IDX_W'($urandom_range(0, span - 1));
      else
        idx = IDX_W'($urandom_range(0, MEM_DEPTH - 1));
      if (idx >= frame_len || stored_ok[idx]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int frame_length();
    int pick;
    pick = $urandom_range(0, 3);
    if (pick == 0 && min_len >= 1 && min_len <= 64) return int'(min_len);
    if (pick == 1 && max_len >= 1 && max_len <= 64) return int'(max_len);
    if (pick == 2 && max_len < 64) return int'(max_len) + 1;
    return $urandom_range(1, 48);
  endfunction

  task automatic send_word(input cmd_t c, input logic [CAP_W-1:0] cap,
                           input logic [IDX_W-1:0] idx, input bit typed = 1'b0,
                           input cap_result_t want = '0);
    cap_result_t due;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.cmd           <= c;
    item_ch.capture_value <= cap;
    item_ch.read_index    <= idx;
    do @(posedge clk); while (!item_ch.ready);
    due = predict_capture(c, cap, idx);
    capture_results_due.push_back(typed ? want : due);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_read();
    logic [IDX_W-1:0] idx;
    if (safe_read_index(idx))
      send_word(CMD_READ, CAP_W'($urandom), idx);
    else
      send_word(CMD_TICK, CAP_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic send_noise();
    cmd_t c;
    c = cmd_t'($urandom_range(0, 3));
    if (c == CMD_READ)
      send_read();
    else
      send_word(c, CAP_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic close_frame();
    send_word(CMD_TICK, CAP_W'($urandom), IDX_W'($urandom));
    if ($urandom_range(0, 3) == 0) begin
      send_word(CMD_EDGE, CAP_W'($urandom), IDX_W'($urandom));
      send_word(CMD_TICK, CAP_W'($urandom), IDX_W'($urandom));
    end
    send_word(CMD_TICK, CAP_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic run_sequence();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      if ($urandom_range(0, 9) != 0) send_word(CMD_LEARN, CAP_W'($urandom), IDX_W'($urandom));
      n = frame_length();
      repeat (n) begin
        send_word(CMD_EDGE, CAP_W'($urandom), IDX_W'($urandom));
        if ($urandom_range(0, 15) == 0) send_noise();
      end
      close_frame();
      repeat ($urandom_range(0, 3)) send_read();
    end else if (kind < 7) begin
      n = $urandom_range(1, 20);
      repeat (n) send_word(CMD_EDGE, CAP_W'($urandom), IDX_W'($urandom));
      close_frame();
    end else begin
      repeat ($urandom_range(1, 6)) send_noise();
    end
  endtask

  task automatic wait_drain();
    item_ch.valid <= 1'b0;
    while (capture_results_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_sel_t sel, input logic [CNT_W-1:0] value);
    repeat (2) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= sel;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (sel == CFG_MIN_EDGES) min_len = value;
    else max_len = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(4_000_000);
    $display("** ir_pulse_learn_capture: FAILED **");
    $finish;
  end

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_long = 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cap_result_t got;
    cap_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.status       = status_t'(res_ch.status);
      got.edge_count   = res_ch.edge_count;
      got.next_rising  = res_ch.next_edge_rising;
      got.learning     = res_ch.learning_active;
      got.saved_length = res_ch.saved_length;
      got.last_capture = res_ch.last_capture;
      got.read_data    = res_ch.read_data;
      if (capture_results_due.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result word: %s", result_text(got));
      end else begin
        want = capture_results_due.pop_front();
        if (got !== want) begin
          fails++;
          if (fails <= 10)
            $display("result mismatch\n  expected %s\n  actual   %s",
                     result_text(want), result_text(got));
        end
      end
    end
  end

  initial begin
    int               phase;
    logic [CNT_W-1:0] lo;
    logic [CNT_W-1:0] hi;

    rst                   <= 1'b1;
    item_ch.valid         <= 1'b0;
    item_ch.cmd           <= CMD_EDGE;
    item_ch.capture_value <= '0;
    item_ch.read_index    <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_MIN_EDGES;
    cfg_ch.data           <= '0;

    edges_seen    = '0;
    edges_at_tick = '0;
    tick_armed    = 1'b0;
    rising_next   = 1'b0;
    learning      = 1'b0;
    frame_len     = '0;
    last_dur      = '0;
    min_len       = MIN_EDGES_RST;
    max_len       = MAX_EDGES_RST;
    items_sent    = 0;
    fails         = 0;
    gaps_on       = 1'b1;
    hold_long     = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < $size(DIRECTED); r++) begin
      if (DIRECTED[r].kind == ROW_REG) begin
        wait_drain();
        write_reg(DIRECTED[r].sel, DIRECTED[r].value);
      end else begin
        send_word(DIRECTED[r].cmd, DIRECTED[r].cap, DIRECTED[r].idx,
                  DIRECTED[r].typed, DIRECTED[r].want);
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_drain();
      case (phase)
        0: begin lo = 10'd0;   hi = 10'd512; end
        1: begin lo = 10'd512; hi = 10'd0;   end
        2: begin lo = 10'd0;   hi = 10'd0;   end
        3: begin lo = 10'd512; hi = 10'd512; end
        4: begin lo = MIN_EDGES_RST; hi = MAX_EDGES_RST; end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            lo = CNT_W'($urandom_range(0, 512));
            hi = CNT_W'($urandom_range(0, 512));
          end else begin
            lo = CNT_W'($urandom_range(0, 20));
            hi = CNT_W'($urandom_range(int'(lo), 40));
          end
        end
      endcase
      write_reg(CFG_MIN_EDGES, lo);
      write_reg(CFG_MAX_EDGES, hi);
      gaps_on = (phase % 4 != 2) && (items_sent < QUIET_START);

      // fill the store past its depth and saturate the edge count
      if (phase == 3) begin
        send_word(CMD_LEARN, CAP_W'($urandom), IDX_W'($urandom));
        repeat (int'(COUNT_MAX) + 8) send_word(CMD_EDGE, CAP_W'($urandom), IDX_W'($urandom));
        send_word(CMD_TICK, CAP_W'($urandom), IDX_W'($urandom));
        send_word(CMD_TICK, CAP_W'($urandom), IDX_W'($urandom));
        repeat (24) send_read();
      end

      if (phase % 3 == 1 && items_sent < QUIET_START) hold_long = 1'b1;
      for (int s = 0; s < 10; s++) begin
        gaps_on = (phase % 4 != 2) && (items_sent < QUIET_START);
        run_sequence();
      end
      phase++;
    end

    wait_drain();
    repeat (8) @(negedge clk);
    if (fails == 0)
      $display("** ir_pulse_learn_capture: PASSED **");
    else
      $display("** ir_pulse_learn_capture: FAILED **");
    $finish;
  end

endmodule
